// File: src/mvf_pkg.sv
// Shared types, constants and command codes for the MVCC visibility filter.
// Depends on nothing; every other file of the block imports it.
package mvf_pkg;

    // Table geometry and id width.
    localparam int ACTIVE_SLOTS = 32;
    localparam int ID_BITS      = 32;

    // Ids travel as 32-bit fields; they are compared in their low ID_W bits, all 32 at the default ID_BITS.
    localparam int FIELD_W = 32;
    localparam int ID_W    = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
    localparam int IDX_W   = $clog2(ACTIVE_SLOTS);
    localparam int CNT_W   = $clog2(ACTIVE_SLOTS + 1);
    localparam int CNT_OUT_W = 6;

    // Beat widths.
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ISOLATION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TXN_ID         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_ID     = 2'd2;

    // Commands.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    typedef logic [ID_W-1:0] mvf_id_t;

    // Lookup keys broadcast to every cell for the duration of a walk.
    typedef struct packed {
        mvf_id_t key_a;
        mvf_id_t key_b;
    } mvf_query_t;

    // Token and running hit flags handed from cell to cell.
    typedef struct packed {
        logic tok;
        logic hit_a;
        logic hit_b;
    } mvf_link_t;

    // Table update strobes from the controller.
    typedef struct packed {
        logic             clr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        mvf_id_t          wr_id;
    } mvf_tbl_ctl_t;

endpackage

// File: src/mvcc_visibility_filter_unit.sv
// Top level of the MVCC visibility filter: controller plus a chain of table cells.
// Depends on mvf_pkg, mvf_cell and mvf_ctrl.
//
// Each s_ beat is one command: clear the active-id table, add one id to it, or
// check one record version against the reading transaction; every command
// returns exactly one m_ beat with visible, overflow and the table fill count.
// The table is a row of ACTIVE_SLOTS cells; a lookup token walks the row one cell
// per cycle, gathering "xmin is active" and "xmax is active" flags on the way.
// Add and check therefore hold the block from one accepted beat to the next for
// the whole walk through the cell row; clear and unknown commands skip the walk
// and go straight to the result stage. One command is worked at a time;
// a finished result waits in the output register while the next beat is taken.
// Configuration writes (cfg_index 0 isolation mode, 1 txn id, 2 command id) take
// effect on the clock edge that sees cfg_wr_en; write them only while the block
// is idle. Unused cfg_index codes are dropped.
module mvcc_visibility_filter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [mvf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mvf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // command beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] command, [33:2] active_id, [65:34] rec_xmin, [97:66] rec_xmax,
    // [129:98] rec_cid, [130] rec_deleted, [135:131] zero
    input  logic [mvf_pkg::S_DATA_W-1:0]      s_tdata,
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] visible, [1] overflow, [7:2] active_count
    output logic [mvf_pkg::M_DATA_W-1:0]      m_tdata
);
    import mvf_pkg::*;

    mvf_query_t   query;
    mvf_tbl_ctl_t tbl_ctl;
    mvf_link_t    chain_head;
    mvf_link_t    links [ACTIVE_SLOTS+1];

    mvf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .query      (query),
        .chain_head (chain_head),
        .chain_tail (links[ACTIVE_SLOTS]),
        .tbl_ctl    (tbl_ctl)
    );

    assign links[0] = chain_head;

    // Build the cell row; each cell registers its stage of the walk and
    // takes the write when its slot index matches the fill count.
    for (genvar i = 0; i < ACTIVE_SLOTS; i++) begin : g_cell
        logic cell_we;
        assign cell_we = tbl_ctl.wr_en && (tbl_ctl.wr_idx == IDX_W'(i));

        mvf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .query    (query),
            .clr      (tbl_ctl.clr),
            .wr_en    (cell_we),
            .wr_id    (tbl_ctl.wr_id),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

endmodule

// File: src/mvf_cell.sv
// One slot of the active-id table: stored id, valid bit and a chain stage.
// Depends on mvf_pkg.
module mvf_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  mvf_pkg::mvf_query_t query,
    input  logic               clr,
    input  logic               wr_en,
    input  mvf_pkg::mvf_id_t   wr_id,
    input  mvf_pkg::mvf_link_t link_in,
    output mvf_pkg::mvf_link_t link_out
);
    import mvf_pkg::*;

    mvf_id_t   id_reg;
    logic      valid_reg;
    logic      valid_next;
    mvf_link_t link_reg;
    mvf_link_t link_next;

    always_comb begin
        valid_next = valid_reg;
        if (clr) begin
            valid_next = 1'b0;
        end else if (wr_en) begin
            valid_next = 1'b1;
        end
    end

    // Fold this slot's match into the flags and pass the token on.
    always_comb begin
        link_next.tok   = link_in.tok;
        link_next.hit_a = link_in.hit_a | (valid_reg && (id_reg == query.key_a));
        link_next.hit_b = link_in.hit_b | (valid_reg && (id_reg == query.key_b));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            link_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            link_reg  <= link_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_reg <= wr_id;
        end
    end

    assign link_out = link_reg;

endmodule

// File: src/mvf_ctrl.sv
// Sequencer, configuration registers, visibility rules and output register.
// Depends on mvf_pkg; drives the cell chain built in the top level.
module mvf_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mvf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mvf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mvf_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mvf_pkg::M_DATA_W-1:0]        m_tdata,
    output mvf_pkg::mvf_query_t                 query,
    output mvf_pkg::mvf_link_t                  chain_head,
    input  mvf_pkg::mvf_link_t                  chain_tail,
    output mvf_pkg::mvf_tbl_ctl_t               tbl_ctl
);
    import mvf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             launch_reg, launch_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             hit_a_reg, hit_b_reg;

    // Configuration.
    logic    mode_reg;
    mvf_id_t txn_reg;
    mvf_id_t cmd_id_reg;

    // Captured item.
    logic [1:0] cmd_reg;
    mvf_id_t    key_a_reg;
    mvf_id_t    key_b_reg;
    mvf_id_t    cid_reg;
    logic       del_reg;

    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic       s_accept;
    logic       commit;
    logic [1:0] in_cmd;
    logic       table_full;
    logic       vis;
    logic       ovf;
    logic       ins_ok;
    logic       del_ok;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

    assign in_cmd   = s_tdata[1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign table_full = (count_reg == CNT_W'(ACTIVE_SLOTS));

    // Visibility rules on the captured record.
    always_comb begin
        ins_ok = (key_a_reg == txn_reg) ||
                 ((key_a_reg != '0) && !hit_a_reg && (!mode_reg || (key_a_reg < txn_reg)));
        del_ok = (key_b_reg != txn_reg) &&
                 ((key_b_reg == '0) || hit_b_reg || (mode_reg && (key_b_reg > txn_reg)));
        if (cmd_reg != CMD_CHECK) begin
            vis = 1'b0;
        end else if (txn_reg == '0) begin
            vis = !del_reg;
        end else if ((key_a_reg == txn_reg) && (cid_reg == cmd_id_reg)) begin
            vis = 1'b0;
        end else begin
            vis = ins_ok && del_ok;
        end
    end

    assign ovf = (cmd_reg == CMD_ADD) && !hit_a_reg && table_full;

    always_comb begin
        count_next = count_reg;
        if (commit) begin
            case (cmd_reg)
                CMD_CLEAR: count_next = '0;
                CMD_ADD: begin
                    if (!hit_a_reg && !table_full) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default: count_next = count_reg;
            endcase
        end
    end

    assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_next};

    always_comb begin
        m_data_next = m_data_reg;
        if (commit) begin
            m_data_next = {cnt_ext[CNT_OUT_W-1:0], ovf, vis};
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb begin
        state_next  = state_reg;
        launch_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if ((in_cmd == CMD_ADD) || (in_cmd == CMD_CHECK)) begin
                        state_next  = ST_WALK;
                        launch_next = 1'b1;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_WALK: begin
                if (chain_tail.tok) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launch_reg   <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            mode_reg     <= 1'b0;
            txn_reg      <= '0;
            cmd_id_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            launch_reg   <= launch_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ISOLATION_MODE: mode_reg   <= cfg_wdata[0];
                    REG_TXN_ID:         txn_reg    <= cfg_wdata[ID_W-1:0];
                    REG_COMMAND_ID:     cmd_id_reg <= cfg_wdata[ID_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_accept) begin
            cmd_reg   <= in_cmd;
            key_a_reg <= (in_cmd == CMD_ADD) ? s_tdata[2 +: ID_W] : s_tdata[34 +: ID_W];
            key_b_reg <= s_tdata[66 +: ID_W];
            cid_reg   <= s_tdata[98 +: ID_W];
            del_reg   <= s_tdata[130];
        end
        if ((state_reg == ST_WALK) && chain_tail.tok) begin
            hit_a_reg <= chain_tail.hit_a;
            hit_b_reg <= chain_tail.hit_b;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    assign query.key_a = key_a_reg;
    assign query.key_b = key_b_reg;

    assign chain_head.tok   = launch_reg;
    assign chain_head.hit_a = 1'b0;
    assign chain_head.hit_b = 1'b0;

    assign tbl_ctl.clr    = commit && (cmd_reg == CMD_CLEAR);
    assign tbl_ctl.wr_en  = commit && (cmd_reg == CMD_ADD) && !hit_a_reg && !table_full;
    assign tbl_ctl.wr_idx = count_reg[IDX_W-1:0];
    assign tbl_ctl.wr_id  = key_a_reg;

    // The token only leaves the chain during a walk.
    a_tok_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_tail.tok |-> (state_reg == ST_WALK))
        else $error("token left the chain outside a walk");

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ACTIVE_SLOTS))
        else $error("active count beyond table depth");

    // An overflowing add leaves the table size alone.
    a_ovf_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && ovf) |=> $stable(count_reg))
        else $error("count moved on overflow");

    // A lookup command launches a token in the next cycle.
    a_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && ((in_cmd == CMD_ADD) || (in_cmd == CMD_CHECK))) |=> launch_reg)
        else $error("lookup accepted without a token launch");

    // No table write while the table is full.
    a_no_wr_full: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_ctl.wr_en |-> !table_full)
        else $error("table write with the table full");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for mvcc_visibility_filter_unit: streams clear, add,
// check and unknown commands under several reader settings and compares every result beat.
// Depends on mvf_pkg and the RTL of the block only.

module testbench;
    import mvf_pkg::*;

    // Command code 3 has no meaning; the block answers it with the count only.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // Chance in percent that either side sits out a cycle.
    localparam int IDLE_PCT = 38;

    // Drain time after the last result: one full walk of the table plus margin.
    localparam int TAIL_CYCLES = ACTIVE_SLOTS + 16;

    typedef struct {
        logic [1:0]         command;
        logic [FIELD_W-1:0] active_id;
        logic [FIELD_W-1:0] rec_xmin;
        logic [FIELD_W-1:0] rec_xmax;
        logic [FIELD_W-1:0] rec_cid;
        logic               rec_deleted;
    } cmd_beat_t;

    typedef struct {
        logic                 visible;
        logic                 overflow;
        logic [CNT_OUT_W-1:0] active_count;
    } filter_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    wire                   s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    wire                   m_tvalid;
    logic                  m_tready  = 1'b0;
    wire  [M_DATA_W-1:0]   m_tdata;

    // Reader settings and active-id table as the block should hold them.
    bit        snap_mode;
    mvf_id_t   reader_txn;
    mvf_id_t   reader_cid;
    mvf_id_t   live_ids[$];

    // Ids handed out by the stimulus since its last clear; used only to pick
    // record ids that hit the table and repeat adds, never for prediction.
    mvf_id_t   added_ids[$];

    cmd_beat_t      pending_beats[$];
    filter_result_t expected_results[$];
    cmd_beat_t      beat_on_bus;
    bit             s_taken;
    bit             calm;
    int unsigned    n_queued;
    int unsigned    n_taken;
    int unsigned    n_fail;

    mvcc_visibility_filter_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Visibility prediction
    // ------------------------------------------------------------------

    function automatic bit is_live(input mvf_id_t id);
        foreach (live_ids[i]) begin
            if (live_ids[i] == id) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit record_visible(input mvf_id_t xmin, input mvf_id_t xmax,
                                          input mvf_id_t cid, input logic deleted);
        bit ins_ok;
        bit del_ok;
        // No reader: only the legacy deleted mark counts.
        if (reader_txn == '0) return !deleted;
        // Rows written by the running statement stay out of its own scan.
        if (xmin == reader_txn && cid == reader_cid) return 1'b0;
        ins_ok = (xmin == reader_txn) ||
                 (xmin != '0 && !is_live(xmin) && (!snap_mode || xmin < reader_txn));
        del_ok = (xmax != reader_txn) &&
                 (xmax == '0 || is_live(xmax) || (snap_mode && xmax > reader_txn));
        return ins_ok && del_ok;
    endfunction

    // Advance the table by one command and return the result beat it must give.
    function automatic filter_result_t apply_command(input cmd_beat_t c);
        filter_result_t r;
        mvf_id_t        id;
        r.visible  = 1'b0;
        r.overflow = 1'b0;
        if (c.command == CMD_CLEAR) begin
            live_ids.delete();
        end else if (c.command == CMD_ADD) begin
            id = mvf_id_t'(c.active_id);
            // A duplicate leaves the table as it is; a new id on a full table is dropped.
            if (!is_live(id)) begin
                if (live_ids.size() < ACTIVE_SLOTS) live_ids.push_back(id);
                else r.overflow = 1'b1;
            end
        end else if (c.command == CMD_CHECK) begin
            r.visible = record_visible(mvf_id_t'(c.rec_xmin), mvf_id_t'(c.rec_xmax),
                                       mvf_id_t'(c.rec_cid), c.rec_deleted);
        end
        r.active_count = CNT_OUT_W'(live_ids.size());
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic cmd_beat_t noise_beat();
        cmd_beat_t c;
        c.command     = 2'($urandom_range(3));
        c.active_id   = $urandom;
        c.rec_xmin    = $urandom;
        c.rec_xmax    = $urandom;
        c.rec_cid     = $urandom;
        c.rec_deleted = 1'($urandom_range(1));
        return c;
    endfunction

    // Favor ids around the reader and ids in the table, where the rules split.
    function automatic mvf_id_t pick_id();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) return '0;
        if (sel <= 2) return reader_txn;
        if (sel == 3) return reader_txn - mvf_id_t'($urandom_range(20, 1));
        if (sel == 4) return reader_txn + mvf_id_t'($urandom_range(20, 1));
        if (sel <= 7 && added_ids.size() != 0)
            return added_ids[$urandom_range(added_ids.size() - 1)];
        return mvf_id_t'($urandom);
    endfunction

    function automatic mvf_id_t pick_cid();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel <= 3) return reader_cid;
        if (sel == 4) return reader_cid + mvf_id_t'(1);
        if (sel == 5) return reader_cid - mvf_id_t'(1);
        return mvf_id_t'($urandom);
    endfunction

    function automatic mvf_id_t add_candidate();
        if (added_ids.size() != 0 && $urandom_range(4) == 0)
            return added_ids[$urandom_range(added_ids.size() - 1)];
        if ($urandom_range(1) == 0)
            return reader_txn + mvf_id_t'($urandom_range(64)) - mvf_id_t'(32);
        return mvf_id_t'($urandom);
    endfunction

    task automatic push_beat(input cmd_beat_t c);
        pending_beats.push_back(c);
        n_queued++;
    endtask

    task automatic queue_clear();
        cmd_beat_t c;
        c = noise_beat();
        c.command = CMD_CLEAR;
        push_beat(c);
        added_ids.delete();
    endtask

    task automatic queue_add(input mvf_id_t id);
        cmd_beat_t c;
        c = noise_beat();
        c.command   = CMD_ADD;
        c.active_id = id;
        push_beat(c);
        added_ids.push_back(id);
    endtask

    task automatic queue_check(input mvf_id_t xmin, input mvf_id_t xmax,
                               input mvf_id_t cid, input logic deleted);
        cmd_beat_t c;
        c = noise_beat();
        c.command     = CMD_CHECK;
        c.rec_xmin    = xmin;
        c.rec_xmax    = xmax;
        c.rec_cid     = cid;
        c.rec_deleted = deleted;
        push_beat(c);
    endtask

    // Mostly record checks against a table rebuilt now and then, some of the
    // rebuilds long enough to run the table full; a little raw noise on top.
    task automatic random_phase(input int unsigned n);
        int unsigned stop;
        int unsigned sel;
        int unsigned k;
        stop = n_queued + n;
        while (n_queued < stop) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
                queue_clear();
                k = ($urandom_range(3) == 0) ? $urandom_range(40, 33) : $urandom_range(12);
                repeat (k) queue_add(add_candidate());
            end else if (sel < 15) begin
                queue_add(add_candidate());
            end else if (sel < 19) begin
                push_beat(noise_beat());
            end else begin
                queue_check(pick_id(), ($urandom_range(9) < 4) ? mvf_id_t'(0) : pick_id(),
                            pick_cid(), 1'($urandom_range(1)));
            end
        end
    endtask

    // Hold until every queued beat went in and every result came back.
    task automatic wait_idle();
        while (n_taken != n_queued || expected_results.size() != 0) @(negedge aclk);
    endtask

    // Write all three registers, one per cycle, once the block has drained.
    task automatic set_reader(input bit mode, input mvf_id_t txn, input mvf_id_t cid);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ISOLATION_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(negedge aclk);
        cfg_index <= REG_TXN_ID;
        cfg_wdata <= txn;
        @(negedge aclk);
        cfg_index <= REG_COMMAND_ID;
        cfg_wdata <= cid;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        snap_mode  = mode;
        reader_txn = txn;
        reader_cid = cid;
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next beat on the falling edge once the current
    // one is taken; stall the result side at random.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_taken) begin
                if (pending_beats.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    beat_on_bus = pending_beats.pop_front();
                    s_tdata  <= {5'b0, beat_on_bus.rec_deleted, beat_on_bus.rec_cid,
                                 beat_on_bus.rec_xmax, beat_on_bus.rec_xmin,
                                 beat_on_bus.active_id, beat_on_bus.command};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted command beat, check every result
    // beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        filter_result_t want;
        if (aresetn) begin
            s_taken = s_tvalid && s_tready;
            if (s_taken) begin
                expected_results.push_back(apply_command(beat_on_bus));
                n_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no command outstanding: m_tdata %h", m_tdata);
                    n_fail++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.visible) begin
                        $error("visible: expected %0d, got %0d", want.visible, m_tdata[0]);
                        n_fail++;
                    end
                    if (m_tdata[1] !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d", want.overflow, m_tdata[1]);
                        n_fail++;
                    end
                    if (m_tdata[7:2] !== want.active_count) begin
                        $error("active_count: expected %0d, got %0d",
                               want.active_count, m_tdata[7:2]);
                        n_fail++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cmd_beat_t c;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: no reader, so only the deleted mark decides.
        random_phase(180);

        // Directed: snapshot reader 100 at command 7, table {50, 150, all ones}.
        set_reader(1'b1, mvf_id_t'(100), mvf_id_t'(7));
        queue_clear();
        queue_add(mvf_id_t'(50));
        queue_add(mvf_id_t'(50));           // duplicate, table unchanged
        queue_add(mvf_id_t'(150));
        queue_add('1);
        queue_check(mvf_id_t'(100), '0, mvf_id_t'(7), 1'b0);  // own insert, same command
        queue_check(mvf_id_t'(100), '0, mvf_id_t'(6), 1'b0);  // own insert, earlier command
        queue_check(mvf_id_t'(50), '0, mvf_id_t'(3), 1'b0);   // inserter still active
        queue_check(mvf_id_t'(40), '0, mvf_id_t'(3), 1'b1);   // old committed, mark ignored
        queue_check(mvf_id_t'(200), '0, mvf_id_t'(3), 1'b0);  // inserter newer than reader
        queue_check(mvf_id_t'(40), mvf_id_t'(100), mvf_id_t'(3), 1'b0); // deleted by reader
        queue_check(mvf_id_t'(40), mvf_id_t'(150), mvf_id_t'(3), 1'b0); // deleter active
        queue_check(mvf_id_t'(40), mvf_id_t'(300), mvf_id_t'(3), 1'b0); // deleter newer
        queue_check(mvf_id_t'(40), mvf_id_t'(60), mvf_id_t'(3), 1'b0);  // deleter committed
        queue_check('0, '0, mvf_id_t'(3), 1'b0);                        // null inserter
        queue_check('1, '1, '1, 1'b1);
        c = noise_beat();
        c.command     = CMD_UNKNOWN;
        c.active_id   = '1;
        c.rec_xmin    = '1;
        c.rec_xmax    = '1;
        c.rec_cid     = '1;
        c.rec_deleted = 1'b1;
        push_beat(c);
        queue_clear();
        queue_check(mvf_id_t'(50), '0, mvf_id_t'(3), 1'b0);   // 50 no longer active
        random_phase(200);

        set_reader(1'b0, mvf_id_t'(100), mvf_id_t'(7));
        random_phase(200);

        // Run both sides without idling for one whole phase.
        set_reader(1'b0, mvf_id_t'(1), '0);
        calm = 1'b1;
        random_phase(200);
        wait_idle();
        calm = 1'b0;

        set_reader(1'b1, '1, '1);
        random_phase(200);

        set_reader(1'b1, '0, mvf_id_t'($urandom));
        random_phase(150);

        set_reader(1'b0, mvf_id_t'($urandom), mvf_id_t'($urandom));
        random_phase(200);

        set_reader(1'b1, mvf_id_t'($urandom), mvf_id_t'($urandom));
        random_phase(200);

        set_reader(1'b1, mvf_id_t'(32'h8000_0000), '0);
        random_phase(200);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_fail == 0) begin
            $display("** mvcc_visibility_filter_unit: PASSED **");
        end else begin
            $display("** mvcc_visibility_filter_unit: FAILED **");
        end
        $finish;
    end

    // Guard against a hang: well over the slowest legal run.
    initial begin
        #8_000_000;
        $display("** mvcc_visibility_filter_unit: FAILED **");
        $finish;
    end

endmodule
